FILE: sv/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    // fixed field widths
    localparam int ORD_W  = 6;
    localparam int SIZE_W = 19;
    localparam int FLAG_W = 6;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SM_BEST  = 2'd0,
        SM_HIT   = 2'd1,
        SM_CHILD = 2'd2,
        SM_IDLE  = 2'd3
    } t_scan_mode;

    // descriptor flags, lowest bits of an entry
    typedef struct packed {
        logic has_parent;
        logic side;
        logic is_free;
        logic is_split;
        logic was_split;
        logic live;
    } t_flags;

    // scan unit status toward the sequencer
    typedef struct packed {
        logic done;
        logic a_found;
        logic b_found;
    } t_scan_stat;

    // true when a block of 2^ord pages holds size pages
    function automatic logic fits(logic [ORD_W-1:0] ord, logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] blk;
        blk = (SIZE_W + 1)'(1) << ord;
        if (ord >= ORD_W'(SIZE_W)) begin
            return 1'b1;
        end
        return blk >= {1'b0, size};
    endfunction

endpackage
`default_nettype wire

FILE: sv/bpa_ram.sv
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/bpa_scan.sv
`default_nettype none
module bpa_scan #(
    parameter int FRAME_BITS = 36,
    parameter int IDX_W      = 10,
    parameter int CNT_W      = 11,
    parameter int ENT_W      = 60
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  bpa_pkg::t_scan_mode       i_mode,
    input  wire [FRAME_BITS-1:0]      i_key_frame,
    input  wire [bpa_pkg::SIZE_W-1:0] i_key_size,
    input  wire [IDX_W-1:0]           i_key_par,
    input  wire [CNT_W-1:0]           i_count,
    input  wire [ENT_W-1:0]           i_rd_data,
    output logic                      o_rd_en,
    output logic [IDX_W-1:0]          o_rd_addr,
    output bpa_pkg::t_scan_stat       o_stat,
    output logic [IDX_W-1:0]          o_a_idx,
    output logic [ENT_W-1:0]          o_a_ent,
    output logic [IDX_W-1:0]          o_b_idx,
    output logic [ENT_W-1:0]          o_b_ent
);
    import bpa_pkg::*;

    localparam int ORD_LO = FLAG_W;
    localparam int PAR_LO = FLAG_W + ORD_W;
    localparam int FR_LO  = PAR_LO + IDX_W;

    logic             r_busy, r_pend, r_a_found, r_b_found;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pidx, r_par;
    t_scan_mode       r_mode;
    logic [ORD_W-1:0] r_a_ord;

    t_flags           e_fl;
    logic [ORD_W-1:0] e_ord;
    logic [IDX_W-1:0] e_par;
    logic [FRAME_BITS-1:0] e_frame;
    logic             take_a, take_b;

    assign e_fl    = t_flags'(i_rd_data[FLAG_W-1:0]);
    assign e_ord   = i_rd_data[ORD_LO +: ORD_W];
    assign e_par   = i_rd_data[PAR_LO +: IDX_W];
    assign e_frame = i_rd_data[FR_LO +: FRAME_BITS];

    // walk the used entries one read per cycle
    assign o_rd_en   = r_busy && (r_idx < i_count);
    assign o_rd_addr = r_idx[IDX_W-1:0];
    assign o_stat.done    = r_busy && !r_pend && !(r_idx < i_count);
    assign o_stat.a_found = r_a_found;
    assign o_stat.b_found = r_b_found;

    // match test on the entry returned by the memory
    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        case (r_mode)
            SM_BEST: begin
                take_a = e_fl.is_free && e_fl.live && fits(e_ord, i_key_size) &&
                         (!r_a_found || e_ord < r_a_ord);
            end
            SM_HIT: begin
                take_a = !r_a_found && e_frame == i_key_frame && e_fl.live &&
                         !e_fl.is_free && !e_fl.is_split;
            end
            SM_CHILD: begin
                take_a = !r_a_found && e_fl.has_parent && e_par == r_par && !e_fl.side;
                take_b = !r_b_found && e_fl.has_parent && e_par == r_par && e_fl.side;
            end
            default: begin
                take_a = 1'b0;
                take_b = 1'b0;
            end
        endcase
        if (!r_pend) begin
            take_a = 1'b0;
            take_b = 1'b0;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pend    <= 1'b0;
            r_a_found <= 1'b0;
            r_b_found <= 1'b0;
            r_mode    <= SM_IDLE;
            r_idx     <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_pend    <= 1'b0;
            r_a_found <= 1'b0;
            r_b_found <= 1'b0;
            r_mode    <= i_mode;
            r_idx     <= '0;
        end else begin
            r_pend <= o_rd_en;
            if (o_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (o_stat.done) begin
                r_busy <= 1'b0;
            end
            if (take_a) begin
                r_a_found <= 1'b1;
            end
            if (take_b) begin
                r_b_found <= 1'b1;
            end
        end
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_par <= i_key_par;
        end
        if (o_rd_en) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
        if (take_a) begin
            o_a_idx <= r_pidx;
            o_a_ent <= i_rd_data;
            r_a_ord <= e_ord;
        end
        if (take_b) begin
            o_b_idx <= r_pidx;
            o_b_ent <= i_rd_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/buddy_page_allocator.sv
// sequence: add writes one entry; allocate and free take one pass over the N used entries,
//   one more pass per merge level and per split of a block that was split before,
//   table writes per level, then the output register
// throughput: one item at a time; the shared table scan sets the figure
// reset: entry count cleared; the descriptor memory is not cleared, only
//   entries below the count are ever read
`default_nettype none
module buddy_page_allocator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_ORDER   = 18,
    parameter int FRAME_BITS  = 36
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [35:0] i_frame,
    input  wire  [4:0]  i_order,
    input  wire  [18:0] i_size_pages,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [35:0] o_granted_frame,
    output logic [4:0]  o_granted_order,
    output logic [1:0]  o_status
);
    import bpa_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W  = FRAME_BITS + IDX_W + ORD_W + FLAG_W;
    localparam int ORD_LO = FLAG_W;
    localparam int PAR_LO = FLAG_W + ORD_W;
    localparam int FR_LO  = PAR_LO + IDX_W;

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_ADD      = 17'b00000000000000010,
        S_A_SCAN   = 17'b00000000000000100,
        S_A_CHK    = 17'b00000000000001000,
        S_A_CSCAN  = 17'b00000000000010000,
        S_A_NEW    = 17'b00000000000100000,
        S_A_NEW_R  = 17'b00000000001000000,
        S_A_REUSEL = 17'b00000000010000000,
        S_A_REUSER = 17'b00000000100000000,
        S_A_PAR    = 17'b00000001000000000,
        S_A_FIN    = 17'b00000010000000000,
        S_F_SCAN   = 17'b00000100000000000,
        S_M_SCAN   = 17'b00001000000000000,
        S_M_WL     = 17'b00010000000000000,
        S_M_WR     = 17'b00100000000000000,
        S_M_WQ     = 17'b01000000000000000,
        S_OUT      = 17'b10000000000000000
    } t_state;

    function automatic logic [ENT_W-1:0] mk_ent(logic [FRAME_BITS-1:0] fr,
                                                logic [IDX_W-1:0] par,
                                                logic [ORD_W-1:0] ord, t_flags fl);
        return {fr, par, ord, fl};
    endfunction

    function automatic logic [ENT_W-1:0] set_fl(logic [ENT_W-1:0] e, t_flags fl);
        return {e[ENT_W-1:FLAG_W], fl};
    endfunction

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [ORD_W-1:0]      r_order, n_order;
    logic [IDX_W-1:0]      r_cur, n_cur, r_child, n_child, r_q, n_q;
    logic [ENT_W-1:0]      r_cur_ent, n_cur_ent, r_child_ent, n_child_ent;
    logic [ENT_W-1:0]      r_q_ent, n_q_ent;
    logic [FRAME_BITS-1:0] r_res_frame, n_res_frame;
    logic [ORD_W-1:0]      r_res_ord, n_res_ord;
    t_status               r_status, n_status;

    logic             we, re, s_start, s_rd_en;
    logic [IDX_W-1:0] waddr, raddr, s_rd_addr, s_key_par;
    logic [ENT_W-1:0] wdata, rdata;
    t_scan_mode       s_mode;
    t_scan_stat       s_stat;
    logic [IDX_W-1:0] a_idx, b_idx;
    logic [ENT_W-1:0] a_ent, b_ent;

    t_flags                cur_fl, a_fl, b_fl, q_fl;
    logic [ORD_W-1:0]      cur_ord, co;
    logic [FRAME_BITS-1:0] cur_frame;
    logic [IDX_W-1:0]      a_par, q_par;

    assign cur_fl    = t_flags'(r_cur_ent[FLAG_W-1:0]);
    assign cur_ord   = r_cur_ent[ORD_LO +: ORD_W];
    assign cur_frame = r_cur_ent[FR_LO +: FRAME_BITS];
    assign co        = cur_ord - ORD_W'(1);
    assign a_fl      = t_flags'(a_ent[FLAG_W-1:0]);
    assign b_fl      = t_flags'(b_ent[FLAG_W-1:0]);
    assign a_par     = a_ent[PAR_LO +: IDX_W];
    assign q_fl      = t_flags'(r_q_ent[FLAG_W-1:0]);
    assign q_par     = r_q_ent[PAR_LO +: IDX_W];

    bpa_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bpa_scan #(
        .FRAME_BITS (FRAME_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .ENT_W      (ENT_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_start),
        .i_mode      (s_mode),
        .i_key_frame (r_frame),
        .i_key_size  (r_size),
        .i_key_par   (s_key_par),
        .i_count     (r_count),
        .i_rd_data   (rdata),
        .o_rd_en     (s_rd_en),
        .o_rd_addr   (s_rd_addr),
        .o_stat      (s_stat),
        .o_a_idx     (a_idx),
        .o_a_ent     (a_ent),
        .o_b_idx     (b_idx),
        .o_b_ent     (b_ent)
    );

    // read port: scan unit, or the merge step fetching the parent
    assign re    = s_rd_en || (r_state == S_M_WL);
    assign raddr = s_rd_en ? s_rd_addr : r_q;

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_granted_frame = 36'(r_res_frame);
    assign o_granted_order = 5'(r_res_ord);
    assign o_status        = r_status;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_frame     = r_frame;
        n_size      = r_size;
        n_order     = r_order;
        n_cur       = r_cur;
        n_cur_ent   = r_cur_ent;
        n_child     = r_child;
        n_child_ent = r_child_ent;
        n_q         = r_q;
        n_q_ent     = r_q_ent;
        n_res_frame = r_res_frame;
        n_res_ord   = r_res_ord;
        n_status    = r_status;
        we          = 1'b0;
        waddr       = r_count[IDX_W-1:0];
        wdata       = '0;
        s_start     = 1'b0;
        s_mode      = SM_CHILD;
        s_key_par   = r_cur;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_frame     = FRAME_BITS'(i_frame);
                    n_size      = (i_size_pages == '0) ? SIZE_W'(1) : i_size_pages;
                    n_order     = (ORD_W'(i_order) > ORD_W'(MAX_ORDER)) ?
                                  ORD_W'(MAX_ORDER) : ORD_W'(i_order);
                    n_res_frame = '0;
                    n_res_ord   = '0;
                    n_status    = ST_OK;
                    case (t_op'(i_opcode))
                        OP_ADD: begin
                            n_state = S_ADD;
                        end
                        OP_ALLOC: begin
                            s_start = 1'b1;
                            s_mode  = SM_BEST;
                            n_state = S_A_SCAN;
                        end
                        OP_FREE: begin
                            s_start = 1'b1;
                            s_mode  = SM_HIT;
                            n_state = S_F_SCAN;
                        end
                        default: begin
                            n_status = ST_IGNORED;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    we          = 1'b1;
                    wdata       = mk_ent(r_frame, '0, r_order, 6'b001001);
                    n_count     = r_count + CNT_W'(1);
                    n_res_frame = r_frame;
                    n_res_ord   = r_order;
                end
                n_state = S_OUT;
            end
            S_A_SCAN: begin
                if (s_stat.done) begin
                    if (!s_stat.a_found) begin
                        n_status = ST_NOFIT;
                        n_state  = S_OUT;
                    end else begin
                        n_cur     = a_idx;
                        n_cur_ent = a_ent;
                        n_state   = S_A_CHK;
                    end
                end
            end
            S_A_CHK: begin
                // halve while the lower order still holds the request
                if (cur_ord != '0 && fits(co, r_size)) begin
                    if (cur_fl.was_split) begin
                        s_start   = 1'b1;
                        s_key_par = r_cur;
                        n_state   = S_A_CSCAN;
                    end else begin
                        n_state = S_A_NEW;
                    end
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_A_CSCAN: begin
                if (s_stat.done) begin
                    n_state = (s_stat.a_found && s_stat.b_found) ? S_A_REUSEL : S_A_NEW;
                end
            end
            S_A_NEW: begin
                if ((CNT_W + 1)'(r_count) + (CNT_W + 1)'(2) > (CNT_W + 1)'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                    n_state  = S_OUT;
                end else begin
                    we          = 1'b1;
                    wdata       = mk_ent(cur_frame, r_cur, co, 6'b101001);
                    n_child     = r_count[IDX_W-1:0];
                    n_child_ent = wdata;
                    n_count     = r_count + CNT_W'(1);
                    n_state     = S_A_NEW_R;
                end
            end
            S_A_NEW_R: begin
                we      = 1'b1;
                wdata   = mk_ent(cur_frame + (FRAME_BITS'(1) << co), r_cur, co, 6'b111001);
                n_count = r_count + CNT_W'(1);
                n_state = S_A_PAR;
            end
            S_A_REUSEL: begin
                we          = 1'b1;
                waddr       = a_idx;
                wdata       = set_fl(a_ent, '{has_parent: a_fl.has_parent, side: a_fl.side,
                                     is_free: 1'b1, is_split: a_fl.is_split,
                                     was_split: a_fl.was_split, live: 1'b1});
                n_child     = a_idx;
                n_child_ent = wdata;
                n_state     = S_A_REUSER;
            end
            S_A_REUSER: begin
                we      = 1'b1;
                waddr   = b_idx;
                wdata   = set_fl(b_ent, '{has_parent: b_fl.has_parent, side: b_fl.side,
                                 is_free: 1'b1, is_split: b_fl.is_split,
                                 was_split: b_fl.was_split, live: 1'b1});
                n_state = S_A_PAR;
            end
            S_A_PAR: begin
                we        = 1'b1;
                waddr     = r_cur;
                wdata     = set_fl(r_cur_ent, '{has_parent: cur_fl.has_parent,
                                   side: cur_fl.side, is_free: 1'b0, is_split: 1'b1,
                                   was_split: 1'b1, live: cur_fl.live});
                n_cur     = r_child;
                n_cur_ent = r_child_ent;
                n_state   = S_A_CHK;
            end
            S_A_FIN: begin
                we          = 1'b1;
                waddr       = r_cur;
                wdata       = set_fl(r_cur_ent, '{has_parent: cur_fl.has_parent,
                                     side: cur_fl.side, is_free: 1'b0,
                                     is_split: cur_fl.is_split,
                                     was_split: cur_fl.was_split, live: cur_fl.live});
                n_res_frame = cur_frame;
                n_res_ord   = cur_ord;
                n_state     = S_OUT;
            end
            S_F_SCAN: begin
                if (s_stat.done) begin
                    if (!s_stat.a_found) begin
                        n_status = ST_IGNORED;
                        n_state  = S_OUT;
                    end else begin
                        we          = 1'b1;
                        waddr       = a_idx;
                        wdata       = set_fl(a_ent, '{has_parent: a_fl.has_parent,
                                             side: a_fl.side, is_free: 1'b1,
                                             is_split: a_fl.is_split,
                                             was_split: a_fl.was_split, live: a_fl.live});
                        n_res_frame = a_ent[FR_LO +: FRAME_BITS];
                        n_res_ord   = a_ent[ORD_LO +: ORD_W];
                        if (a_fl.has_parent && CNT_W'(a_par) < r_count) begin
                            n_q       = a_par;
                            s_start   = 1'b1;
                            s_key_par = a_par;
                            n_state   = S_M_SCAN;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_M_SCAN: begin
                if (s_stat.done) begin
                    if (s_stat.a_found && s_stat.b_found && a_fl.is_free && b_fl.is_free) begin
                        n_state = S_M_WL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_M_WL: begin
                we      = 1'b1;
                waddr   = a_idx;
                wdata   = set_fl(a_ent, '{has_parent: a_fl.has_parent, side: a_fl.side,
                                 is_free: 1'b0, is_split: a_fl.is_split,
                                 was_split: a_fl.was_split, live: 1'b0});
                n_state = S_M_WR;
            end
            S_M_WR: begin
                we      = 1'b1;
                waddr   = b_idx;
                wdata   = set_fl(b_ent, '{has_parent: b_fl.has_parent, side: b_fl.side,
                                 is_free: 1'b0, is_split: b_fl.is_split,
                                 was_split: b_fl.was_split, live: 1'b0});
                n_q_ent = rdata;
                n_state = S_M_WQ;
            end
            S_M_WQ: begin
                we    = 1'b1;
                waddr = r_q;
                wdata = set_fl(r_q_ent, '{has_parent: q_fl.has_parent, side: q_fl.side,
                               is_free: 1'b1, is_split: 1'b0, was_split: 1'b1,
                               live: q_fl.live});
                // climb to the grandparent while it exists
                if (q_fl.has_parent && CNT_W'(q_par) < r_count) begin
                    n_q       = q_par;
                    s_start   = 1'b1;
                    s_key_par = q_par;
                    n_state   = S_M_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_frame     <= n_frame;
        r_size      <= n_size;
        r_order     <= n_order;
        r_cur       <= n_cur;
        r_cur_ent   <= n_cur_ent;
        r_child     <= n_child;
        r_child_ent <= n_child_ent;
        r_q         <= n_q;
        r_q_ent     <= n_q_ent;
        r_res_frame <= n_res_frame;
        r_res_ord   <= n_res_ord;
        r_status    <= n_status;
    end

    // checks
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid high together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.done |-> (r_state == S_A_SCAN || r_state == S_A_CSCAN ||
                         r_state == S_F_SCAN || r_state == S_M_SCAN))
        else $error("scan finished outside a scan state");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rd_en |-> !we)
        else $error("table written during a scan read");

endmodule
`default_nettype wire
